FILE: sv/bra_pkg.sv
// Package for the bitmap run allocator: store geometry, field widths,
// request modes, register indexes and status codes.
// No dependencies.
package bra_pkg;

    localparam int SECTOR_BYTES    = 512;
    localparam int MAX_MAP_SECTORS = 8;
    localparam int STORE_BYTES     = SECTOR_BYTES * MAX_MAP_SECTORS;

    localparam int ADDR_W     = $clog2(STORE_BYTES);
    localparam int NB_W       = ADDR_W + 1;
    localparam int BIT_W      = ADDR_W + 3;
    localparam int TOTAL_W    = NB_W + 3;

    localparam int BYTE_IDX_W = 12;
    localparam int BYTE_W     = 8;
    localparam int LEN_W      = 16;
    localparam int MS_W       = 4;
    localparam int FDS_W      = 24;
    localparam int SEC_W      = 25;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_W      = 24;

    localparam int CMP_W = (TOTAL_W > LEN_W) ? TOTAL_W : LEN_W;

    localparam logic [BYTE_W-1:0] BYTE_FULL = 8'hFF;

    typedef enum logic
    {
        MODE_LOAD  = 1'b0,
        MODE_ALLOC = 1'b1
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        CFG_MAP_SECTORS = 2'd0,
        CFG_FIRST_DATA  = 2'd1
    } cfg_idx_t;

    typedef enum logic [1:0]
    {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_BLOCKED = 2'd2
    } status_t;

endpackage

FILE: sv/bra_ram.sv
// Generic single-clock RAM: one write port, one read port with registered data.
// No dependencies.
module bra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: sv/bitmap_run_allocator_top.sv
// Top level of the bitmap first-fit run allocator.
// Depends on bra_pkg and bra_ram (bitmap byte store).
//
// Usage:
//   Requests enter on in_valid/in_ready with mode, byte_index, byte_value and
//   run_length; each request gives one result on out_valid/out_ready with
//   status and first_sector. Registers are written through cfg_we, cfg_index
//   and cfg_data; the user must write them only while the block is idle,
//   which the block does not enforce. A load request writes one bitmap byte
//   when it is accepted. An allocate request runs on the bitmap store (one
//   write port, one read port with registered data), one access per cycle:
//     scan:  read and test each byte up to the first byte that is not all ones
//     check: test the length, then read and test each byte spanned by the run
//     mark:  read, then write back, each byte spanned by the run
//   and then posts its result. Requests are taken one at a time; a new
//   request is accepted once the previous one has handed its result to the
//   output register, even while that result still waits.
//   Reset sets map_sectors to 1 and first_data_sector to 0 and clears all
//   handshake state; the bitmap contents are undefined until loaded.
//   When the receiver stalls, the result holds in the output register and a
//   following request stalls in its final state until the register frees.
module bitmap_run_allocator_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          mode,
    input  logic [bra_pkg::BYTE_IDX_W-1:0] byte_index,
    input  logic [bra_pkg::BYTE_W-1:0]     byte_value,
    input  logic [bra_pkg::LEN_W-1:0]      run_length,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    status,
    output logic [bra_pkg::SEC_W-1:0]      first_sector,
    input  logic                          cfg_we,
    input  logic [bra_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bra_pkg::CFG_W-1:0]      cfg_data
);

    import bra_pkg::*;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_LEN,
        S_CHK_RD,
        S_CHK_TEST,
        S_MRK_RD,
        S_MRK_WR
    } state_t;

    state_t              state_reg, state_next;
    logic                done_reg, done_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [BIT_W-1:0]    start_reg, start_next;
    logic [BIT_W-1:0]    end_reg, end_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [NB_W-1:0]     nbytes_reg, nbytes_next;
    status_t             res_status_reg, res_status_next;
    logic [SEC_W-1:0]    res_sector_reg, res_sector_next;
    logic                out_valid_reg, out_valid_next;
    status_t             status_reg, status_next;
    logic [SEC_W-1:0]    first_sector_reg, first_sector_next;

    logic [MS_W-1:0]     ms_reg;
    logic [FDS_W-1:0]    fds_reg;

    logic                ram_we, ram_re;
    logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
    logic [BYTE_W-1:0]   ram_wdata, ram_rdata;

    logic [31:0]         ms_sat;
    logic [NB_W-1:0]     nbytes_cur;
    logic [2:0]          zero_bit;
    logic [BYTE_W-1:0]   run_mask;
    logic [CMP_W-1:0]    room;
    logic [CMP_W-1:0]    run_end;
    logic                last_run_byte;
    logic                out_free;
    logic                load_ok;

    bra_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_BYTES)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    function automatic logic [BYTE_W-1:0] byte_mask(
        input logic [ADDR_W-1:0] addr,
        input logic [BIT_W-1:0]  first_bit,
        input logic [BIT_W-1:0]  last_bit
    );
        logic [2:0] lo;
        logic [2:0] hi;
        lo = (addr == first_bit[BIT_W-1:3]) ? first_bit[2:0] : 3'd0;
        hi = (addr == last_bit[BIT_W-1:3]) ? last_bit[2:0] : 3'd7;
        return (BYTE_FULL << lo) & (BYTE_FULL >> (3'd7 - hi));
    endfunction

    always_comb
    begin
        ms_sat = (32'(ms_reg) > 32'(MAX_MAP_SECTORS)) ? 32'(MAX_MAP_SECTORS) : 32'(ms_reg);
        nbytes_cur = NB_W'(ms_sat * 32'(SECTOR_BYTES));
    end

    always_comb
    begin
        zero_bit = 3'd0;
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            if (!ram_rdata[i])
            begin
                zero_bit = 3'(i);
            end
        end
    end

    assign run_mask      = byte_mask(addr_reg, start_reg, end_reg);
    assign last_run_byte = (addr_reg == end_reg[BIT_W-1:3]);
    assign room          = CMP_W'({nbytes_reg, 3'b000}) - CMP_W'(start_reg);
    assign run_end       = CMP_W'(start_reg) + CMP_W'(len_reg) - CMP_W'(1);
    assign out_free      = !out_valid_reg || out_ready;
    assign load_ok       = 32'(byte_index) < 32'(STORE_BYTES);

    assign in_ready = (state_reg == S_IDLE) && !done_reg;

    always_comb
    begin
        state_next        = state_reg;
        done_next         = done_reg;
        addr_next         = addr_reg;
        start_next        = start_reg;
        end_next          = end_reg;
        len_next          = len_reg;
        nbytes_next       = nbytes_reg;
        res_status_next   = res_status_reg;
        res_sector_next   = res_sector_reg;
        out_valid_next    = out_valid_reg;
        status_next       = status_reg;
        first_sector_next = first_sector_reg;
        ram_we            = 1'b0;
        ram_waddr         = addr_reg;
        ram_wdata         = ram_rdata | run_mask;
        ram_re            = 1'b0;
        ram_raddr         = addr_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (done_reg)
                begin
                    if (out_free)
                    begin
                        out_valid_next    = 1'b1;
                        status_next       = res_status_reg;
                        first_sector_next = res_sector_reg;
                        done_next         = 1'b0;
                    end
                end
                else if (in_valid)
                begin
                    res_status_next = ST_OK;
                    res_sector_next = '0;
                    len_next        = run_length;
                    nbytes_next     = nbytes_cur;
                    addr_next       = '0;
                    if (mode == MODE_LOAD)
                    begin
                        ram_we    = load_ok;
                        ram_waddr = ADDR_W'(byte_index);
                        ram_wdata = byte_value;
                        done_next = 1'b1;
                    end
                    else if (nbytes_cur == '0)
                    begin
                        res_status_next = ST_FULL;
                        done_next       = 1'b1;
                    end
                    else
                    begin
                        state_next = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD:
            begin
                ram_re     = 1'b1;
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (ram_rdata != BYTE_FULL)
                begin
                    start_next = {addr_reg, zero_bit};
                    state_next = S_LEN;
                end
                else if ({1'b0, addr_reg} == nbytes_reg - NB_W'(1))
                begin
                    res_status_next = ST_FULL;
                    done_next       = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    addr_next  = addr_reg + ADDR_W'(1);
                    state_next = S_SCAN_RD;
                end
            end
            S_LEN:
            begin
                if (len_reg == '0 || CMP_W'(len_reg) > room)
                begin
                    res_status_next = ST_BLOCKED;
                    done_next       = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    end_next   = run_end[BIT_W-1:0];
                    addr_next  = start_reg[BIT_W-1:3];
                    state_next = S_CHK_RD;
                end
            end
            S_CHK_RD:
            begin
                ram_re     = 1'b1;
                state_next = S_CHK_TEST;
            end
            S_CHK_TEST:
            begin
                if ((ram_rdata & run_mask) != '0)
                begin
                    res_status_next = ST_BLOCKED;
                    done_next       = 1'b1;
                    state_next      = S_IDLE;
                end
                else if (last_run_byte)
                begin
                    addr_next  = start_reg[BIT_W-1:3];
                    state_next = S_MRK_RD;
                end
                else
                begin
                    addr_next  = addr_reg + ADDR_W'(1);
                    state_next = S_CHK_RD;
                end
            end
            S_MRK_RD:
            begin
                ram_re     = 1'b1;
                state_next = S_MRK_WR;
            end
            S_MRK_WR:
            begin
                ram_we = 1'b1;
                if (last_run_byte)
                begin
                    res_status_next = ST_OK;
                    res_sector_next = SEC_W'(start_reg) + SEC_W'(fds_reg) - SEC_W'(1);
                    done_next       = 1'b1;
                    state_next      = S_IDLE;
                end
                else
                begin
                    addr_next  = addr_reg + ADDR_W'(1);
                    state_next = S_MRK_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg         <= addr_next;
        start_reg        <= start_next;
        end_reg          <= end_next;
        len_reg          <= len_next;
        nbytes_reg       <= nbytes_next;
        res_status_reg   <= res_status_next;
        res_sector_reg   <= res_sector_next;
        status_reg       <= status_next;
        first_sector_reg <= first_sector_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ms_reg  <= MS_W'(1);
            fds_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_MAP_SECTORS)
            begin
                ms_reg <= cfg_data[MS_W-1:0];
            end
            else if (cfg_index == CFG_FIRST_DATA)
            begin
                fds_reg <= cfg_data[FDS_W-1:0];
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign first_sector = first_sector_reg;

    a_no_sector_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg != ST_OK) |-> first_sector_reg == '0)
        else $error("failed request carries a sector number");

    a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_MRK_WR) ||
                   (state_reg == S_IDLE && in_valid && !done_reg && mode == MODE_LOAD))
        else $error("bitmap write outside load or mark");

    a_run_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CHK_TEST || state_reg == S_MRK_WR) |->
            addr_reg <= end_reg[BIT_W-1:3] && addr_reg >= start_reg[BIT_W-1:3])
        else $error("run byte address outside the run");

    a_mark_ok: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MRK_WR && last_run_byte |=> done_reg && res_status_reg == ST_OK)
        else $error("completed mark did not post an ok result");

    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE || done_reg) |-> !in_ready)
        else $error("request accepted while busy");

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// Testbench for bitmap_run_allocator_top: a directed table, then random load/allocate
// phases across several register settings, checked against a built-in allocator mirror.
// Depends on bra_pkg and the bitmap_run_allocator_top RTL.
module tb;
    import bra_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int TAIL_CYCLES    = 64;
    localparam int PHASES         = 7;
    localparam int DIRECTED_N     = 23;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

    typedef struct packed {
        mode_t              md;
        logic [BYTE_IDX_W-1:0] idx;
        logic [BYTE_W-1:0]  val;
        logic [LEN_W-1:0]   len;
        logic               known;
        status_t            st;
        logic [SEC_W-1:0]   sec;
    } stim_row_t;

    typedef struct packed {
        status_t          st;
        logic [SEC_W-1:0] sec;
    } alloc_result_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  mode = MODE_LOAD;
    logic [BYTE_IDX_W-1:0] byte_index = '0;
    logic [BYTE_W-1:0]     byte_value = '0;
    logic [LEN_W-1:0]      run_length = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [1:0]            status;
    logic [SEC_W-1:0]      first_sector;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data = '0;

    logic [BYTE_W-1:0] map_mirror [STORE_BYTES];
    bit                byte_written [STORE_BYTES];
    logic [MS_W-1:0]   mirror_map_sectors = 4'd1;
    logic [FDS_W-1:0]  mirror_first_data = '0;

    alloc_result_t pending_results [$];
    int unsigned   mismatch_count = 0;
    int unsigned   idle_cycles = 0;
    int unsigned   burst_left = 0;
    int unsigned   ready_mode = 0;
    int unsigned   ready_left = 0;

    int unsigned phase_ms [PHASES] = '{1, 2, 0, 15, 8, 3, 1};
    int unsigned phase_items [PHASES] = '{90, 90, 20, 80, 70, 90, 75};

    stim_row_t directed_rows [DIRECTED_N] = '{
        '{MODE_ALLOC, 12'd0,    8'h00, 16'd1,     1'b1, ST_OK,      25'h1FFFFFF},
        '{MODE_ALLOC, 12'd0,    8'h00, 16'd0,     1'b1, ST_BLOCKED, 25'd0},
        '{MODE_ALLOC, 12'd0,    8'h00, 16'hFFFF,  1'b1, ST_BLOCKED, 25'd0},
        '{MODE_ALLOC, 12'd0,    8'h00, 16'd4095,  1'b1, ST_OK,      25'd0},
        '{MODE_ALLOC, 12'd0,    8'h00, 16'd1,     1'b1, ST_FULL,    25'd0},
        '{MODE_LOAD,  12'd4095, 8'hA5, 16'd0,     1'b1, ST_OK,      25'd0},
        '{MODE_LOAD,  12'd0,    8'h00, 16'd0,     1'b1, ST_OK,      25'd0},
        '{MODE_LOAD,  12'd1,    8'h80, 16'd0,     1'b0, ST_OK,      25'd0},
        '{MODE_ALLOC, 12'd0,    8'h00, 16'd15,    1'b0, ST_OK,      25'd0},
        '{MODE_LOAD,  12'd0,    8'hF0, 16'd0,     1'b0, ST_OK,      25'd0},
        '{MODE_LOAD,  12'd1,    8'h00, 16'd0,     1'b0, ST_OK,      25'd0},
        '{MODE_ALLOC, 12'd0,    8'h00, 16'd5,     1'b0, ST_OK,      25'd0},
        '{MODE_LOAD,  12'd0,    8'hFF, 16'd0,     1'b0, ST_OK,      25'd0},
        '{MODE_ALLOC, 12'd0,    8'h00, 16'd3,     1'b0, ST_OK,      25'd0},
        '{MODE_LOAD,  12'd1,    8'h7F, 16'd0,     1'b0, ST_OK,      25'd0},
        '{MODE_LOAD,  12'd2,    8'h00, 16'd0,     1'b0, ST_OK,      25'd0},
        '{MODE_ALLOC, 12'd0,    8'h00, 16'd9,     1'b0, ST_OK,      25'd0},
        '{MODE_LOAD,  12'd511,  8'h00, 16'd0,     1'b0, ST_OK,      25'd0},
        '{MODE_ALLOC, 12'd0,    8'h00, 16'd9,     1'b0, ST_OK,      25'd0},
        '{MODE_ALLOC, 12'd0,    8'h00, 16'd8,     1'b0, ST_OK,      25'd0},
        '{MODE_LOAD,  12'd511,  8'h07, 16'd0,     1'b0, ST_OK,      25'd0},
        '{MODE_ALLOC, 12'd0,    8'h00, 16'd5,     1'b0, ST_OK,      25'd0},
        '{MODE_ALLOC, 12'd0,    8'h00, 16'd1,     1'b1, ST_FULL,    25'd0}
    };

    bitmap_run_allocator_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .byte_index   (byte_index),
        .byte_value   (byte_value),
        .run_length   (run_length),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .first_sector (first_sector),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned bytes_in_use();
        int unsigned ms;
        ms = mirror_map_sectors;
        if (ms > MAX_MAP_SECTORS)
            ms = MAX_MAP_SECTORS;
        return ms * SECTOR_BYTES;
    endfunction

    // Find the first never-loaded byte that an allocate of this length would read.
    function automatic bit touches_unwritten(input logic [LEN_W-1:0] len,
                                             output logic [BYTE_IDX_W-1:0] hole);
        int unsigned nbytes;
        int unsigned start_bit;
        int unsigned last_byte;
        int unsigned j;
        int unsigned k;
        bit          found;
        hole = '0;
        found = 1'b0;
        start_bit = 0;
        nbytes = bytes_in_use();
        for (j = 0; j < nbytes && !found; j++)
        begin
            if (!byte_written[j])
            begin
                hole = BYTE_IDX_W'(j);
                return 1'b1;
            end
            if (map_mirror[j] != BYTE_FULL)
            begin
                k = 0;
                while (k < 8 && map_mirror[j][k])
                    k++;
                start_bit = j * 8 + k;
                found = 1'b1;
            end
        end
        if (!found || len == 0 || len > nbytes * 8 - start_bit)
            return 1'b0;
        last_byte = (start_bit + len - 1) >> 3;
        for (j = start_bit >> 3; j <= last_byte; j++)
        begin
            if (!byte_written[j])
            begin
                hole = BYTE_IDX_W'(j);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic alloc_result_t compute_alloc_result(input logic md,
                                                           input logic [BYTE_IDX_W-1:0] idx,
                                                           input logic [BYTE_W-1:0] val,
                                                           input logic [LEN_W-1:0] len);
        alloc_result_t res;
        int unsigned   nbytes;
        int unsigned   total_bits;
        int unsigned   start_bit;
        int unsigned   j;
        int unsigned   k;
        int unsigned   b;
        bit            found;
        bit            blocked;
        res.st = ST_OK;
        res.sec = '0;
        found = 1'b0;
        blocked = 1'b0;
        start_bit = 0;
        if (md == MODE_LOAD)
        begin
            map_mirror[idx] = val;
            byte_written[idx] = 1'b1;
        end
        else
        begin
            nbytes = bytes_in_use();
            total_bits = nbytes * 8;
            for (j = 0; j < nbytes && !found; j++)
            begin
                if (map_mirror[j] != BYTE_FULL)
                begin
                    k = 0;
                    while (k < 8 && map_mirror[j][k])
                        k++;
                    start_bit = j * 8 + k;
                    found = 1'b1;
                end
            end
            if (!found)
                res.st = ST_FULL;
            else if (len == 0 || len > total_bits - start_bit)
                res.st = ST_BLOCKED;
            else
            begin
                for (b = start_bit; b < start_bit + len; b++)
                    if (map_mirror[b >> 3][b & 7])
                        blocked = 1'b1;
                if (blocked)
                    res.st = ST_BLOCKED;
                else
                begin
                    for (b = start_bit; b < start_bit + len; b++)
                        map_mirror[b >> 3][b & 7] = 1'b1;
                    res.sec = SEC_W'(start_bit) + SEC_W'(mirror_first_data) - SEC_W'(1);
                end
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Request sender: bursts of back-to-back requests separated by random gaps, which may be zero.
    task automatic send_request(input mode_t md, input logic [BYTE_IDX_W-1:0] idx,
                                input logic [BYTE_W-1:0] val, input logic [LEN_W-1:0] len,
                                input logic known, input status_t k_st,
                                input logic [SEC_W-1:0] k_sec);
        int unsigned   gap;
        alloc_result_t res;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
        end
        burst_left--;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= md;
        byte_index <= idx;
        byte_value <= val;
        run_length <= len;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        res = compute_alloc_result(md, idx, val, len);
        if (known)
        begin
            res.st = k_st;
            res.sec = k_sec;
        end
        pending_results.push_back(res);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_config(input logic [MS_W-1:0] ms, input logic [FDS_W-1:0] fds);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MAP_SECTORS;
        cfg_data  <= {(CFG_W - MS_W)'($urandom), ms};
        @(posedge clk);
        cfg_index <= CFG_FIRST_DATA;
        cfg_data  <= fds;
        @(posedge clk);
        cfg_index <= CFG_SPARE_IDX;
        cfg_data  <= CFG_W'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
        mirror_map_sectors = ms;
        mirror_first_data = fds;
    endtask

    task automatic fill_map(input int unsigned count, input bit zeros, input bit only_unwritten);
        int unsigned          j;
        int unsigned          sel;
        logic [BYTE_W-1:0]    val;
        for (j = 0; j < count; j++)
        begin
            if (!only_unwritten || !byte_written[j])
            begin
                sel = $urandom_range(0, 99);
                if (zeros || sel < 60)
                    val = 8'h00;
                else if (sel < 75)
                    val = BYTE_FULL;
                else
                    val = BYTE_W'($urandom);
                send_request(MODE_LOAD, BYTE_IDX_W'(j), val, LEN_W'($urandom), 1'b0, ST_OK, '0);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode <= $urandom_range(0, 2);
            ready_left <= $urandom_range(1, 40);
        end
        else
            ready_left <= ready_left - 1;
        case (ready_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            default: out_ready <= 1'b0;
        endcase
    end

    // Result checker and watchdog.
    always @(posedge clk)
    begin
        alloc_result_t want;
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("unexpected result status", 32'(status), 32'd0);
                else
                begin
                    want = pending_results.pop_front();
                    if (status !== want.st)
                        report_mismatch("status", 32'(status), 32'(want.st));
                    if (first_sector !== want.sec)
                        report_mismatch("first_sector", 32'(first_sector), 32'(want.sec));
                end
            end
        end
    end

    initial
    begin
        int unsigned           p;
        int unsigned           n;
        int unsigned           nb;
        int unsigned           sel;
        mode_t                 md;
        logic [BYTE_IDX_W-1:0] idx;
        logic [BYTE_IDX_W-1:0] hole;
        logic [BYTE_W-1:0]     val;
        logic [LEN_W-1:0]      len;
        logic [FDS_W-1:0]      fds;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        fill_map(SECTOR_BYTES, 1'b1, 1'b1);
        for (n = 0; n < DIRECTED_N; n++)
            send_request(directed_rows[n].md, directed_rows[n].idx, directed_rows[n].val,
                         directed_rows[n].len, directed_rows[n].known,
                         directed_rows[n].st, directed_rows[n].sec);

        for (p = 0; p < PHASES; p++)
        begin
            wait_drained();
            case (p)
                1: fds = 24'hFFFFFF;
                5: fds = 24'h000000;
                6: fds = 24'h000001;
                default: fds = FDS_W'($urandom);
            endcase
            set_config(MS_W'(phase_ms[p]), fds);

            for (n = 0; n < phase_items[p]; n++)
            begin
                nb = bytes_in_use();
                idx = BYTE_IDX_W'($urandom);
                val = BYTE_W'($urandom);
                len = LEN_W'($urandom);
                if ($urandom_range(0, 99) < 35)
                begin
                    md = MODE_LOAD;
                    sel = $urandom_range(0, 99);
                    if (nb > 0 && sel < 40)
                        idx = BYTE_IDX_W'($urandom_range(0, (nb < 64 ? nb : 64) - 1));
                    else if (nb > 0 && sel < 85)
                        idx = BYTE_IDX_W'($urandom_range(0, nb - 1));
                    sel = $urandom_range(0, 99);
                    if (sel < 35)
                        val = 8'h00;
                    else if (sel < 55)
                        val = BYTE_FULL;
                end
                else
                begin
                    md = MODE_ALLOC;
                    sel = $urandom_range(0, 99);
                    if (sel < 55)
                        len = LEN_W'($urandom_range(1, 12));
                    else if (sel < 80)
                        len = LEN_W'($urandom_range(13, 200));
                    else if (sel < 88)
                        len = '0;
                    else if (sel >= 95)
                        len = 16'hFFFF;
                    // load that byte instead when the allocate would read one never loaded
                    if (touches_unwritten(len, hole))
                    begin
                        md = MODE_LOAD;
                        idx = hole;
                    end
                end
                send_request(md, idx, val, len, 1'b0, ST_OK, '0);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
